### src/apm_pkg.sv
// shared types, constants and helpers for the automaton pattern matcher
`default_nettype none
package apm_pkg;

  localparam int MAX_PATTERN   = 16;
  localparam int POSITION_BITS = 32;
  localparam int PATTERN_WORDS = 4;
  localparam int BYTE_W        = 8;
  localparam int WORD_W        = 32;
  localparam int LEN_W         = 5;
  localparam int IDX_W         = $clog2(MAX_PATTERN);
  localparam int CFG_IDX_W     = 3;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 3'd0,
    CFG_PATTERN_WORD_0 = 3'd1,
    CFG_PATTERN_WORD_1 = 3'd2,
    CFG_PATTERN_WORD_2 = 3'd3,
    CFG_PATTERN_WORD_3 = 3'd4
  } cfg_index_t;

  typedef enum logic {
    MODE_RUN  = 1'b0,
    MODE_SYNC = 1'b1
  } mode_t;

  typedef struct packed {
    logic  step;
    logic  flush;
    logic  zero;
    byte_t data;
  } chain_ctl_t;

  typedef struct packed {
    logic             busy;
    logic             step;
    logic             done;
    logic [IDX_W-1:0] idx;
    len_t             target;
  } sync_t;

  function automatic len_t eff_len(input len_t raw);
    len_t m;
    m = raw;
    if (m == '0) begin
      m = len_t'(1);
    end
    if (m > len_t'(MAX_PATTERN)) begin
      m = len_t'(MAX_PATTERN);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### src/automaton_pattern_matcher_top.sv
// top level of the streaming automaton pattern matcher
//
// input channel: in_text_byte and in_start_of_text move on in_valid with in_stall low;
// in_start_of_text clears the matched prefix and the byte position before that byte.
// result channel: one result per input byte on out_valid / out_stall, in input order:
// out_match_found, out_match_start (position of the first matched byte) and
// out_prefix_state (matched prefix length after the byte).
// out_valid rises in the cycle after an input transfer; with in_stall low a byte can be
// taken every cycle, as the chain of compare cells updates all prefix lengths in one step.
// when the receiver stalls, the result register holds and in_stall rises only while
// that held result would otherwise be overwritten.
// config port: cfg_ready is always high; index 0 is the pattern length, 1 to 4 the
// pattern words. after each config write the chain is rebuilt from the stored pattern,
// one pattern byte per cycle, up to the current prefix length cut to the pattern length;
// the input stalls until the rebuild is done.
// reset (rst_n low, synchronous): pattern length 1, pattern words 0, prefix and
// position 0, no result pending.
`default_nettype none
module automaton_pattern_matcher_top
  import apm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BYTE_W-1:0]    in_text_byte,
  input  wire logic                 in_start_of_text,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_match_found,
  output logic [WORD_W-1:0]         out_match_start,
  output logic [LEN_W-1:0]          out_prefix_state,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data
);

  len_t                     len_r;
  logic [WORD_W-1:0]        pat_word_r [PATTERN_WORDS];
  byte_t                    pat [MAX_PATTERN];
  len_t                     m_eff;
  len_t                     st_r;
  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] pos_base;
  logic [POSITION_BITS-1:0] start_pos;
  logic                     out_valid_r;
  logic                     accept;
  logic                     cfg_wr;
  sync_t                    sync;
  chain_ctl_t               ctl;
  logic [MAX_PATTERN-1:0]   hit_nxt;
  logic [MAX_PATTERN-1:0]   hit_r;
  logic [MAX_PATTERN-1:0]   prev_hit;
  logic [MAX_PATTERN-1:0]   in_use;
  len_t                     new_state;
  logic                     match;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_stall  = sync.busy | (out_valid_r & out_stall);
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign m_eff     = eff_len(len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= len_t'(1);
      for (int w = 0; w < PATTERN_WORDS; w++) begin
        pat_word_r[w] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PATTERN_LENGTH: len_r         <= cfg_data[LEN_W-1:0];
        CFG_PATTERN_WORD_0: pat_word_r[0] <= cfg_data;
        CFG_PATTERN_WORD_1: pat_word_r[1] <= cfg_data;
        CFG_PATTERN_WORD_2: pat_word_r[2] <= cfg_data;
        CFG_PATTERN_WORD_3: pat_word_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  apm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .prefix (st_r),
    .len    (m_eff),
    .sync   (sync)
  );

  assign ctl.step  = accept | sync.step;
  assign ctl.flush = accept & in_start_of_text;
  assign ctl.zero  = cfg_wr;
  assign ctl.data  = accept ? in_text_byte : pat[sync.idx];

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    assign pat[k]    = pat_word_r[k / 4][(k % 4) * BYTE_W +: BYTE_W];
    assign in_use[k] = (len_t'(k + 1) <= m_eff);
    if (k == 0) begin : g_first
      assign prev_hit[k] = 1'b1;
    end else begin : g_rest
      assign prev_hit[k] = hit_r[k-1] & ~ctl.flush;
    end
    apm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .prev_hit (prev_hit[k]),
      .in_use   (in_use[k]),
      .pat_byte (pat[k]),
      .hit_nxt  (hit_nxt[k]),
      .hit_r    (hit_r[k])
    );
  end

  always_comb begin
    new_state = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (hit_nxt[k]) begin
        new_state = len_t'(k + 1);
      end
    end
  end

  assign match     = (new_state == m_eff);
  assign pos_base  = in_start_of_text ? '0 : pos_r;
  assign start_pos = pos_base - POSITION_BITS'(m_eff) + POSITION_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        st_r        <= new_state;
        pos_r       <= pos_base + POSITION_BITS'(1);
        out_valid_r <= 1'b1;
      end else begin
        if (sync.done) begin
          st_r <= sync.target;
        end
        if (!out_stall) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_match_found  <= match;
      out_match_start  <= match ? WORD_W'(start_pos) : '0;
      out_prefix_state <= new_state;
    end
  end

endmodule
`default_nettype wire

### src/apm_cell.sv
// one chain cell: tracks whether the pattern prefix ending at its byte matches
`default_nettype none
module apm_cell
  import apm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire chain_ctl_t ctl,
  input  wire logic       prev_hit,
  input  wire logic       in_use,
  input  wire byte_t      pat_byte,
  output logic            hit_nxt,
  output logic            hit_r
);

  assign hit_nxt = prev_hit & in_use & (pat_byte == ctl.data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctl.zero) begin
      hit_r <= 1'b0;
    end else if (ctl.step) begin
      hit_r <= hit_nxt;
    end
  end

endmodule
`default_nettype wire

### src/apm_ctrl.sv
// sequencer that rebuilds the chain from the pattern after a config write
`default_nettype none
module apm_ctrl
  import apm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_wr,
  input  wire len_t prefix,
  input  wire len_t len,
  output sync_t     sync
);

  mode_t mode_r, mode_nxt;
  len_t  cnt_r, cnt_nxt;
  len_t  target;

  assign target = (prefix < len) ? prefix : len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RUN;
      cnt_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    cnt_nxt     = cnt_r;
    sync.busy   = 1'b0;
    sync.step   = 1'b0;
    sync.done   = 1'b0;
    sync.idx    = cnt_r[IDX_W-1:0];
    sync.target = target;
    unique case (mode_r)
      MODE_RUN: begin
        if (cfg_wr) begin
          mode_nxt = MODE_SYNC;
          cnt_nxt  = '0;
        end
      end
      MODE_SYNC: begin
        sync.busy = 1'b1;
        if (cfg_wr) begin
          cnt_nxt = '0;
        end else if (cnt_r != target) begin
          sync.step = 1'b1;
          cnt_nxt   = cnt_r + len_t'(1);
        end else begin
          sync.done = 1'b1;
          mode_nxt  = MODE_RUN;
        end
      end
      default: begin
        mode_nxt = MODE_RUN;
      end
    endcase
  end

endmodule
`default_nettype wire
